// ----- rtl/tcwc_pkg.sv -----
// shared types, constants and datapath command codes of the congestion window controller
package tcwc_pkg;

	localparam int SEQ_W  = 16;
	localparam int FRAC_W = 16;
	localparam int TIME_W = 32;
	localparam int DUP_W  = 3;
	localparam int SIZE_W = SEQ_W + 1;
	localparam int END_W  = SIZE_W + 1;
	localparam int QUOT_W = FRAC_W + 1;
	localparam int CNT_W  = $clog2(FRAC_W + 1);

	localparam logic [DUP_W-1:0] DUP_LIMIT       = DUP_W'(3);
	localparam logic [SEQ_W-1:0] PKT_COUNT_RST   = SEQ_W'(1024);
	localparam logic [SEQ_W-1:0] INIT_THRESH_RST = SEQ_W'(64);

	localparam logic CMD_ACK     = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic {
		CFG_PACKET_COUNT = 1'b0,
		CFG_INIT_THRESH  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              cmd;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] pkt_stamp;
		logic [TIME_W-1:0] now;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0] win_first;
		logic [SEQ_W-1:0] win_last;
		logic             in_avoidance;
		logic [SEQ_W-1:0] thresh_now;
		logic             resend;
		logic [SEQ_W-1:0] resend_seq;
		logic             send_fin;
		logic             ignored;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_IGNORE,
		OP_CUT,
		OP_PREP,
		OP_SLOW,
		OP_DUP_IGNORE,
		OP_DUP_CUT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_GROW,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic timeout;
		logic stale_ack;
		logic stale_timeout;
		logic avoid;
		logic dup_trip;
		logic cut_stale;
		logic div_last;
	} dp_status_t;

endpackage

// ----- rtl/tcwc_datapath.sv -----
// window state, event registers, reciprocal divider and result register
module tcwc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcwc_pkg::dp_cmd_t    cmd,
	output tcwc_pkg::dp_status_t status,
	input  tcwc_pkg::in_item_t   in_data,
	output tcwc_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  tcwc_pkg::cfg_index_t cfg_index,
	input  logic [15:0]          cfg_data
);

	function automatic logic [tcwc_pkg::SEQ_W-1:0] place_end(
		input logic [tcwc_pkg::SEQ_W-1:0] start,
		input logic [tcwc_pkg::END_W-1:0] size,
		input logic [tcwc_pkg::SEQ_W-1:0] bound
	);
		logic [tcwc_pkg::END_W-1:0] e;
		e = {2'b00, start} + size - tcwc_pkg::END_W'(1);
		if (e < {2'b00, bound})
			return e[tcwc_pkg::SEQ_W-1:0];
		return bound;
	endfunction

	logic [tcwc_pkg::SEQ_W-1:0]  pkt_count_q;
	logic [tcwc_pkg::SEQ_W-1:0]  first_q;
	logic [tcwc_pkg::SEQ_W-1:0]  last_q;
	logic [tcwc_pkg::SEQ_W-1:0]  thresh_q;
	logic                        avoid_q;
	logic [tcwc_pkg::DUP_W-1:0]  dup_q;
	logic [tcwc_pkg::FRAC_W-1:0] frac_q;
	logic [tcwc_pkg::TIME_W-1:0] ignore_q;
	logic                        resend_q;
	logic                        fin_q;
	logic                        ignored_q;
	logic [tcwc_pkg::CNT_W-1:0]  cnt_q;

	logic                        ev_cmd_q;
	logic [tcwc_pkg::SEQ_W-1:0]  ev_seq_q;
	logic [tcwc_pkg::TIME_W-1:0] ev_stamp_q;
	logic [tcwc_pkg::TIME_W-1:0] ev_now_q;
	logic [tcwc_pkg::SIZE_W-1:0] rem_q;
	logic [tcwc_pkg::SIZE_W-1:0] div_q;
	logic [tcwc_pkg::QUOT_W-1:0] quot_q;
	tcwc_pkg::out_item_t         out_q;

	logic [tcwc_pkg::SIZE_W-1:0]   size_cur;
	logic [tcwc_pkg::SIZE_W-1:0]   size_slow;
	logic [tcwc_pkg::SEQ_W-1:0]    bound;
	logic                          fin_hit;
	logic [tcwc_pkg::DUP_W-1:0]    dup_next;
	logic [tcwc_pkg::SIZE_W:0]     trial;
	logic                          trial_ge;
	logic                          dbit;
	logic [tcwc_pkg::FRAC_W+1:0]   acc;
	logic [tcwc_pkg::END_W-1:0]    size_grow;

	always_comb begin
		if (last_q < first_q)
			size_cur = tcwc_pkg::SIZE_W'(1);
		else
			size_cur = {1'b0, last_q} - {1'b0, first_q} + tcwc_pkg::SIZE_W'(1);
		size_slow = size_cur + tcwc_pkg::SIZE_W'(1);
		bound = (pkt_count_q == '0) ? '0 : pkt_count_q - tcwc_pkg::SEQ_W'(1);
		fin_hit = (ev_seq_q == pkt_count_q);
		if (fin_hit || (ev_seq_q == first_q))
			dup_next = dup_q + tcwc_pkg::DUP_W'(1);
		else
			dup_next = '0;
		dbit = (cnt_q == tcwc_pkg::CNT_W'(tcwc_pkg::FRAC_W));
		trial = {rem_q, dbit};
		trial_ge = (trial >= {1'b0, div_q});
		acc = {2'b00, frac_q} + {1'b0, quot_q};
		size_grow = {1'b0, size_cur} + {{(tcwc_pkg::END_W-2){1'b0}},
			acc[tcwc_pkg::FRAC_W+1:tcwc_pkg::FRAC_W]};
	end

	assign status.timeout       = (ev_cmd_q == tcwc_pkg::CMD_TIMEOUT);
	assign status.stale_ack     = (ev_seq_q < first_q);
	assign status.stale_timeout = (ev_stamp_q < ignore_q);
	assign status.avoid         = avoid_q;
	assign status.dup_trip      = (dup_q > tcwc_pkg::DUP_LIMIT);
	assign status.cut_stale     = (ev_now_q < ignore_q);
	assign status.div_last      = (cnt_q == '0);

	assign out_data = out_q;

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_count_q <= tcwc_pkg::PKT_COUNT_RST;
			first_q     <= '0;
			last_q      <= '0;
			thresh_q    <= tcwc_pkg::INIT_THRESH_RST;
			avoid_q     <= 1'b0;
			dup_q       <= '0;
			frac_q      <= '0;
			ignore_q    <= '0;
			resend_q    <= 1'b0;
			fin_q       <= 1'b0;
			ignored_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tcwc_pkg::CFG_PACKET_COUNT: pkt_count_q <= cfg_data;
					tcwc_pkg::CFG_INIT_THRESH:  thresh_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (cmd.op)
				tcwc_pkg::OP_LOAD: begin
					resend_q  <= 1'b0;
					fin_q     <= 1'b0;
					ignored_q <= 1'b0;
				end
				tcwc_pkg::OP_IGNORE: begin
					ignored_q <= 1'b1;
				end
				tcwc_pkg::OP_CUT: begin
					ignore_q <= ev_now_q;
					avoid_q  <= 1'b0;
					thresh_q <= size_cur[tcwc_pkg::SIZE_W-1:1];
					last_q   <= first_q;
					resend_q <= 1'b1;
				end
				tcwc_pkg::OP_PREP: begin
					if (fin_hit) begin
						first_q <= ev_seq_q;
						last_q  <= ev_seq_q;
						fin_q   <= 1'b1;
					end
					if (avoid_q)
						dup_q <= dup_next;
				end
				tcwc_pkg::OP_SLOW: begin
					first_q <= ev_seq_q;
					last_q  <= place_end(ev_seq_q, {1'b0, size_slow}, bound);
					if (size_slow > {1'b0, thresh_q})
						avoid_q <= 1'b1;
				end
				tcwc_pkg::OP_DUP_IGNORE: begin
					dup_q     <= '0;
					ignored_q <= 1'b1;
				end
				tcwc_pkg::OP_DUP_CUT: begin
					dup_q    <= '0;
					ignore_q <= ev_now_q;
					avoid_q  <= 1'b0;
					thresh_q <= size_cur[tcwc_pkg::SIZE_W-1:1];
					last_q   <= first_q;
					resend_q <= 1'b1;
				end
				tcwc_pkg::OP_DIV_INIT: begin
					cnt_q <= tcwc_pkg::CNT_W'(tcwc_pkg::FRAC_W);
				end
				tcwc_pkg::OP_DIV_STEP: begin
					cnt_q <= cnt_q - tcwc_pkg::CNT_W'(1);
				end
				tcwc_pkg::OP_GROW: begin
					frac_q  <= acc[tcwc_pkg::FRAC_W-1:0];
					first_q <= ev_seq_q;
					last_q  <= place_end(ev_seq_q, size_grow, bound);
				end
				default: ;
			endcase
		end
	end

	// event capture, divider and result payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			tcwc_pkg::OP_LOAD: begin
				ev_cmd_q   <= in_data.cmd;
				ev_seq_q   <= in_data.seq;
				ev_stamp_q <= in_data.pkt_stamp;
				ev_now_q   <= in_data.now;
			end
			tcwc_pkg::OP_DIV_INIT: begin
				div_q  <= size_cur;
				rem_q  <= '0;
				quot_q <= '0;
			end
			tcwc_pkg::OP_DIV_STEP: begin
				if (trial_ge)
					rem_q <= tcwc_pkg::SIZE_W'(trial - {1'b0, div_q});
				else
					rem_q <= trial[tcwc_pkg::SIZE_W-1:0];
				quot_q <= {quot_q[tcwc_pkg::QUOT_W-2:0], trial_ge};
			end
			tcwc_pkg::OP_EMIT: begin
				out_q.win_first    <= first_q;
				out_q.win_last     <= last_q;
				out_q.in_avoidance <= avoid_q;
				out_q.thresh_now   <= thresh_q;
				out_q.resend       <= resend_q;
				out_q.resend_seq   <= resend_q ? ev_seq_q : '0;
				out_q.send_fin     <= fin_q;
				out_q.ignored      <= ignored_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/tcwc_controller.sv -----
// event sequencing state machine of the congestion window controller
module tcwc_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tcwc_pkg::dp_cmd_t    cmd,
	input  tcwc_pkg::dp_status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PHASE,
		S_DIV,
		S_GROW,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.op = tcwc_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					cmd.op = tcwc_pkg::OP_LOAD;
			end
			S_CHECK: begin
				if (status.timeout)
					cmd.op = status.stale_timeout ? tcwc_pkg::OP_IGNORE : tcwc_pkg::OP_CUT;
				else if (status.stale_ack)
					cmd.op = tcwc_pkg::OP_IGNORE;
				else
					cmd.op = tcwc_pkg::OP_PREP;
			end
			S_PHASE: begin
				if (!status.avoid)
					cmd.op = tcwc_pkg::OP_SLOW;
				else if (status.dup_trip)
					cmd.op = status.cut_stale ? tcwc_pkg::OP_DUP_IGNORE
						: tcwc_pkg::OP_DUP_CUT;
				else
					cmd.op = tcwc_pkg::OP_DIV_INIT;
			end
			S_DIV:    cmd.op = tcwc_pkg::OP_DIV_STEP;
			S_GROW:   cmd.op = tcwc_pkg::OP_GROW;
			S_FINISH: begin
				if (slot_free)
					cmd.op = tcwc_pkg::OP_EMIT;
			end
			default: cmd.op = tcwc_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (status.timeout || status.stale_ack)
						state_q <= S_FINISH;
					else
						state_q <= S_PHASE;
				end
				S_PHASE: begin
					if (status.avoid && !status.dup_trip)
						state_q <= S_DIV;
					else
						state_q <= S_FINISH;
				end
				S_DIV: begin
					if (status.div_last)
						state_q <= S_GROW;
				end
				S_GROW: state_q <= S_FINISH;
				S_FINISH: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/tcp_congestion_window_control.sv -----
// top level of the congestion window controller: sequencer plus window datapath
// Reno-style congestion window for one flow. Each transfer on the input channel is an ack
// or a timeout event and produces exactly one result transfer with the updated window,
// phase, threshold and resend/fin/ignored flags. One event is processed at a time; a
// timeout or an ack below the window goes straight to the result, a slow start ack or a
// fourth duplicate ack passes the phase step first, and a congestion avoidance ack also
// runs the 17-step restoring divider that forms the 1/W growth increment. A finished
// result sits in the output register while the next event is accepted; a result that
// is not taken holds the following one back.
// Configuration writes are always ready and take effect in the cycle after the transfer;
// a write of initial_threshold also loads the current threshold.
module tcp_congestion_window_control (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcwc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tcwc_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tcwc_pkg::cfg_index_t cfg_index,
	input  logic [15:0]          cfg_data
);

	tcwc_pkg::dp_cmd_t    dp_cmd;
	tcwc_pkg::dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	tcwc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	tcwc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
